FILE: src/stable_min_priority_queue_assert.svh
// assertion macros for the stable min priority queue checker
// depends on nothing; included by the checker file only
`ifndef STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SMPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/smpq_pkg.sv
// shared constants for the stable min priority queue
// no dependencies; used by the top level and the checker
package smpq_pkg;

    localparam int STATUS_BITS = 2;
    localparam int OCC_BITS    = 5;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

endpackage

FILE: src/smpq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; holds the queue entries
module smpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/stable_min_priority_queue.sv
// channel  dir  signals                        content
// s_axis   in   s_axis_tvalid/tready/tdata     operation, payload, priority_req
// m_axis   out  m_axis_tvalid/tready/tdata     payload_out, priority_out, status, occupancy
//
// enqueue, full or empty cases: the result is registered straight from the transfer
// dequeue: a scan of every entry through the ram read port, then, unless the minimum
// is the last entry, a fetch and a shift of each entry behind the removed one
// one item at a time; a new transfer is taken once the result register drains
// reset (rst_n low, asynchronous) empties the queue; ram contents are not cleared
// top level of the stable min priority queue; depends on smpq_pkg and smpq_ram
module stable_min_priority_queue #(
    parameter int CAPACITY      = 16,
    parameter int PAYLOAD_BITS  = 32,
    parameter int PRIORITY_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // operation, payload, priority_req, zero pad
    input  logic [((PAYLOAD_BITS + PRIORITY_BITS + 8) / 8) * 8 - 1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // payload_out, priority_out, status, occupancy, zero pad
    output logic [((PAYLOAD_BITS + PRIORITY_BITS + smpq_pkg::STATUS_BITS
                    + smpq_pkg::OCC_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int IW      = $clog2(CAPACITY);
    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = PAYLOAD_BITS + PRIORITY_BITS;
    localparam int OUT_W   = ((PAYLOAD_BITS + PRIORITY_BITS + smpq_pkg::STATUS_BITS
                               + smpq_pkg::OCC_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_SHIFT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [PAYLOAD_BITS-1:0] best_pay_reg, best_pay_next;
    logic signed [PRIORITY_BITS-1:0] best_pri_reg, best_pri_next;

    logic out_valid_reg, out_valid_next;
    logic [PAYLOAD_BITS-1:0] out_pay_reg, out_pay_next;
    logic signed [PRIORITY_BITS-1:0] out_pri_reg, out_pri_next;
    logic [smpq_pkg::STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic [smpq_pkg::OCC_BITS-1:0] out_occ_reg, out_occ_next;

    logic wr_en;
    logic [IW-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [IW-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic in_accept;
    logic in_op;
    logic [PAYLOAD_BITS-1:0] in_pay;
    logic signed [PRIORITY_BITS-1:0] in_pri;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic signed [PRIORITY_BITS-1:0] rd_pri;
    logic [CW-1:0] cnt_m1;
    logic [IW-1:0] last_idx;
    logic scan_take;
    logic finish;

    assign in_op  = s_axis_tdata[0];
    assign in_pay = s_axis_tdata[PAYLOAD_BITS:1];
    assign in_pri = s_axis_tdata[ENTRY_W:PAYLOAD_BITS+1];

    assign rd_pay = rd_data[PAYLOAD_BITS-1:0];
    assign rd_pri = rd_data[ENTRY_W-1:PAYLOAD_BITS];

    assign cnt_m1   = cnt_reg - CW'(1);
    assign last_idx = cnt_m1[IW-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // strict less-than keeps the oldest entry on ties
    assign scan_take = (pos_reg == '0) || (rd_pri < best_pri_reg);

    smpq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        best_idx_next   = best_idx_reg;
        best_pay_next   = best_pay_reg;
        best_pri_next   = best_pri_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_pay_next    = out_pay_reg;
        out_pri_next    = out_pri_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = rd_data;
        rd_addr         = '0;
        finish          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    out_pay_next = '0;
                    out_pri_next = '0;
                    if (in_op == smpq_pkg::OP_ENQUEUE)
                    begin
                        out_valid_next = 1'b1;
                        if (cnt_reg == CW'(CAPACITY))
                        begin
                            out_status_next = smpq_pkg::STATUS_FULL;
                            out_occ_next    = smpq_pkg::OCC_BITS'(cnt_reg);
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = cnt_reg[IW-1:0];
                            wr_data         = {in_pri, in_pay};
                            cnt_next        = cnt_reg + CW'(1);
                            out_status_next = smpq_pkg::STATUS_OK;
                            out_occ_next    = smpq_pkg::OCC_BITS'(cnt_reg + CW'(1));
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = smpq_pkg::STATUS_EMPTY;
                        out_occ_next    = '0;
                    end
                    else
                    begin
                        pos_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_addr = pos_reg + IW'(1);
                if (scan_take)
                begin
                    best_idx_next = pos_reg;
                    best_pay_next = rd_pay;
                    best_pri_next = rd_pri;
                end
                if (pos_reg == last_idx)
                begin
                    if (best_idx_next == last_idx)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        pos_next   = best_idx_next;
                        state_next = ST_FETCH;
                    end
                end
                else
                begin
                    pos_next = pos_reg + IW'(1);
                end
            end
            ST_FETCH:
            begin
                rd_addr    = pos_reg + IW'(1);
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = rd_data;
                rd_addr = pos_reg + IW'(2);
                if (pos_reg + IW'(1) == last_idx)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + IW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            out_valid_next  = 1'b1;
            out_pay_next    = best_pay_next;
            out_pri_next    = best_pri_next;
            out_status_next = smpq_pkg::STATUS_OK;
            out_occ_next    = smpq_pkg::OCC_BITS'(cnt_m1);
            cnt_next        = cnt_m1;
            state_next      = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_pay_reg   <= best_pay_next;
        best_pri_reg   <= best_pri_next;
        out_pay_reg    <= out_pay_next;
        out_pri_reg    <= out_pri_next;
        out_status_reg <= out_status_next;
        out_occ_reg    <= out_occ_next;
    end

    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[PAYLOAD_BITS-1:0] = out_pay_reg;
        m_axis_tdata[ENTRY_W-1:PAYLOAD_BITS] = out_pri_reg;
        m_axis_tdata[ENTRY_W+smpq_pkg::STATUS_BITS-1:ENTRY_W] = out_status_reg;
        m_axis_tdata[ENTRY_W+smpq_pkg::STATUS_BITS+smpq_pkg::OCC_BITS-1:
                     ENTRY_W+smpq_pkg::STATUS_BITS] = out_occ_reg;
    end

endmodule

FILE: src/smpq_checker.sv
// port-level checker for the stable min priority queue, bound to the top level
// depends on smpq_pkg and stable_min_priority_queue_assert.svh
`include "stable_min_priority_queue_assert.svh"

module smpq_checker #(
    parameter int CAPACITY      = 16,
    parameter int PAYLOAD_BITS  = 32,
    parameter int PRIORITY_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic [((PAYLOAD_BITS + PRIORITY_BITS + 8) / 8) * 8 - 1:0] s_axis_tdata,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((PAYLOAD_BITS + PRIORITY_BITS + smpq_pkg::STATUS_BITS
                   + smpq_pkg::OCC_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int ENTRY_W = PAYLOAD_BITS + PRIORITY_BITS;
    localparam logic [smpq_pkg::OCC_BITS-1:0] FULL_OCC = smpq_pkg::OCC_BITS'(CAPACITY);

    logic [ENTRY_W-1:0] out_entry;
    logic [smpq_pkg::STATUS_BITS-1:0] out_status;
    logic [smpq_pkg::OCC_BITS-1:0] out_occ;
    logic unused_in;

    assign out_entry  = m_axis_tdata[ENTRY_W-1:0];
    assign out_status = m_axis_tdata[ENTRY_W+smpq_pkg::STATUS_BITS-1:ENTRY_W];
    assign out_occ    = m_axis_tdata[ENTRY_W+smpq_pkg::STATUS_BITS+smpq_pkg::OCC_BITS-1:
                                     ENTRY_W+smpq_pkg::STATUS_BITS];
    assign unused_in  = ^s_axis_tdata;

    // no new transfer is taken while a result sits stalled
    `SMPQ_ASSERT_IMPLY(a_no_take_while_stalled, clk, rst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || m_axis_tready || unused_in != unused_in)

    `SMPQ_ASSERT_IMPLY(a_status_code, clk, rst_n, m_axis_tvalid, out_status == smpq_pkg::STATUS_OK || out_status == smpq_pkg::STATUS_EMPTY || out_status == smpq_pkg::STATUS_FULL)

    `SMPQ_ASSERT_IMPLY(a_empty_result, clk, rst_n, m_axis_tvalid && out_status == smpq_pkg::STATUS_EMPTY, out_occ == '0 && out_entry == '0)

    `SMPQ_ASSERT_IMPLY(a_full_result, clk, rst_n, m_axis_tvalid && out_status == smpq_pkg::STATUS_FULL, out_occ == FULL_OCC && out_entry == '0)

    `SMPQ_ASSERT_NEXT(a_result_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind stable_min_priority_queue smpq_checker #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
) u_smpq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

FILE: bench/tb_stable_min_priority_queue.sv
`timescale 1ns / 1ps
// self-checking bench for the stable min priority queue: directed and random
// enqueue/dequeue traffic with bursty sender and stalling receiver
// depends on smpq_pkg and the stable_min_priority_queue rtl
module tb_stable_min_priority_queue;

    localparam int CAPACITY      = 16;
    localparam int PAYLOAD_BITS  = 32;
    localparam int PRIORITY_BITS = 16;
    localparam int IN_BITS       = ((PAYLOAD_BITS + PRIORITY_BITS + 8) / 8) * 8;
    localparam int OUT_BITS      = ((PAYLOAD_BITS + PRIORITY_BITS + smpq_pkg::STATUS_BITS
                                     + smpq_pkg::OCC_BITS + 7) / 8) * 8;
    localparam int IN_PAD        = IN_BITS - 1 - PAYLOAD_BITS - PRIORITY_BITS;
    localparam int TOTAL_OPS     = 1350;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic                            op;
        logic [PAYLOAD_BITS-1:0]         payload;
        logic signed [PRIORITY_BITS-1:0] prio;
    } queue_op_t;

    typedef struct {
        logic [PAYLOAD_BITS-1:0]         payload;
        logic signed [PRIORITY_BITS-1:0] prio;
    } held_entry_t;

    typedef struct {
        logic [PAYLOAD_BITS-1:0]          payload;
        logic signed [PRIORITY_BITS-1:0]  prio;
        logic [smpq_pkg::STATUS_BITS-1:0] status;
        logic [smpq_pkg::OCC_BITS-1:0]    occupancy;
    } queue_result_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;

    queue_op_t     pending_ops[$];
    held_entry_t   held_entries[$];
    queue_result_t expected_results[$];

    bit          op_taken;
    int          burst_left    = 1;
    int          gap_left      = 0;
    logic [15:0] stall_pattern = 16'hffff;
    int          pattern_age   = 0;
    int          idle_cycles   = 0;
    int          mismatch_count = 0;

    always #10 clk = ~clk;

    stable_min_priority_queue #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .PRIORITY_BITS(PRIORITY_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // operation, payload, priority_req, zero pad
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // payload_out, priority_out, status, occupancy, zero pad
        .m_axis_tdata (m_axis_tdata)
    );

    function automatic queue_result_t apply_queue_op(input queue_op_t item);
        queue_result_t r;
        int            best;
        r.payload = '0;
        r.prio    = '0;
        r.status  = smpq_pkg::STATUS_OK;
        if (item.op == smpq_pkg::OP_ENQUEUE)
        begin
            if (held_entries.size() >= CAPACITY)
                r.status = smpq_pkg::STATUS_FULL;
            else
                held_entries.push_back('{item.payload, item.prio});
        end
        else if (held_entries.size() == 0)
        begin
            r.status = smpq_pkg::STATUS_EMPTY;
        end
        else
        begin
            // strict compare keeps the oldest of equal priorities
            best = 0;
            for (int i = 1; i < held_entries.size(); i++)
                if (held_entries[i].prio < held_entries[best].prio)
                    best = i;
            r.payload = held_entries[best].payload;
            r.prio    = held_entries[best].prio;
            held_entries.delete(best);
        end
        r.occupancy = smpq_pkg::OCC_BITS'(held_entries.size());
        return r;
    endfunction

    task automatic add_op(input logic op, input logic [PAYLOAD_BITS-1:0] payload,
                          input logic signed [PRIORITY_BITS-1:0] prio);
        queue_op_t item;
        item.op      = op;
        item.payload = payload;
        item.prio    = prio;
        pending_ops.push_back(item);
    endtask

    function automatic logic signed [PRIORITY_BITS-1:0] pick_priority();
        logic signed [PRIORITY_BITS-1:0] p;
        case ($urandom_range(0, 3))
            0, 1: p = PRIORITY_BITS'($signed($urandom_range(0, 6)) - 3);
            2:    p = PRIORITY_BITS'($urandom());
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       p = {1'b1, {(PRIORITY_BITS-1){1'b0}}};
                    1:       p = {1'b0, {(PRIORITY_BITS-1){1'b1}}};
                    2:       p = '1;
                    default: p = '0;
                endcase
            end
        endcase
        return p;
    endfunction

    // sender: bursts of transfers with random gaps between them
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || op_taken))
        begin
            op_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                s_axis_tdata  <= {{IN_PAD{1'b0}}, pending_ops[0].prio,
                                  pending_ops[0].payload, pending_ops[0].op};
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern, reloaded now and then
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_axis_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            pattern_age++;
            if (pattern_age == 150)
            begin
                pattern_age   = 0;
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff
                                                            : 16'($urandom()) | 16'h0001;
            end
        end
    end

    always @(posedge clk)
    begin
        queue_result_t got;
        queue_result_t want;
        bit            moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved         = 1'b1;
                got.payload   = m_axis_tdata[PAYLOAD_BITS-1:0];
                got.prio      = m_axis_tdata[PAYLOAD_BITS +: PRIORITY_BITS];
                got.status    = m_axis_tdata[PAYLOAD_BITS + PRIORITY_BITS
                                             +: smpq_pkg::STATUS_BITS];
                got.occupancy = m_axis_tdata[PAYLOAD_BITS + PRIORITY_BITS
                                             + smpq_pkg::STATUS_BITS
                                             +: smpq_pkg::OCC_BITS];
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result: pay %h pri %0d status %0d occ %0d",
                                 got.payload, got.prio, got.status, got.occupancy);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.payload !== want.payload || got.prio !== want.prio ||
                        got.status !== want.status || got.occupancy !== want.occupancy)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"mismatch: expected pay %h pri %0d status %0d occ %0d,",
                                      " got pay %h pri %0d status %0d occ %0d"},
                                     want.payload, want.prio, want.status, want.occupancy,
                                     got.payload, got.prio, got.status, got.occupancy);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved = 1'b1;
                expected_results.push_back(apply_queue_op(pending_ops.pop_front()));
                op_taken = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("stable_min_priority_queue verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int generated;
        int phase_len;
        int enq_pct;
        // empty queue, field extremes, ties, then drain past empty
        add_op(smpq_pkg::OP_DEQUEUE, 32'h0, 16'sh0);
        add_op(smpq_pkg::OP_ENQUEUE, 32'h0000_0000, 16'sh7fff);
        add_op(smpq_pkg::OP_ENQUEUE, 32'hffff_ffff, 16'sh8000);
        add_op(smpq_pkg::OP_ENQUEUE, 32'h1234_5678, 16'sh0000);
        add_op(smpq_pkg::OP_ENQUEUE, 32'h8765_4321, 16'sh0000);
        add_op(smpq_pkg::OP_ENQUEUE, 32'haaaa_5555, 16'shffff);
        add_op(smpq_pkg::OP_ENQUEUE, 32'h5555_aaaa, 16'sh7fff);
        for (int i = 0; i < 6; i++)
            add_op(smpq_pkg::OP_DEQUEUE, $urandom(), PRIORITY_BITS'($urandom()));
        add_op(smpq_pkg::OP_DEQUEUE, 32'hffff_ffff, 16'shffff);
        generated = pending_ops.size();

        // fill, drain and mixed phases so the queue hits full and empty often
        while (generated < TOTAL_OPS)
        begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            phase_len = $urandom_range(5, 40);
            for (int i = 0; i < phase_len && generated < TOTAL_OPS; i++)
            begin
                add_op(($urandom_range(1, 100) <= enq_pct) ? smpq_pkg::OP_ENQUEUE
                                                           : smpq_pkg::OP_DEQUEUE,
                       $urandom(), pick_priority());
                generated++;
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("stable_min_priority_queue verification clean");
        else
            $display("stable_min_priority_queue verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/smpq_pkg.sv
src/smpq_ram.sv
src/stable_min_priority_queue.sv
src/smpq_checker.sv
bench/tb_stable_min_priority_queue.sv
